### rtl/well512_pkg.sv
// ----------------------------------------------------------------------------
// well512_pkg
// Shared types and constants of the WELL512a generator: pool geometry,
// recurrence and hash constants, sequencer states and the pool write request.
// ----------------------------------------------------------------------------
package well512_pkg;

  localparam int unsigned POOL_DEPTH = 16;
  localparam int unsigned POOL_AW    = $clog2(POOL_DEPTH);
  localparam int unsigned DATA_W     = 32;

  localparam logic MODE_RESEED = 1'b1;

  localparam logic [POOL_AW-1:0] OFS_M1   = POOL_AW'(13);
  localparam logic [POOL_AW-1:0] OFS_M2   = POOL_AW'(9);
  localparam logic [POOL_AW-1:0] OFS_BACK = POOL_AW'(POOL_DEPTH - 1);
  localparam logic [POOL_AW-1:0] LAST_IDX = POOL_AW'(POOL_DEPTH - 1);

  localparam logic [DATA_W-1:0] WELL_MAT_MASK = 32'hDA44_2D24;
  localparam logic [DATA_W-1:0] WANG_MUL      = 32'h27D4_EB2D;
  localparam logic [DATA_W-1:0] WANG_XOR      = 32'd61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD13,
    ST_RD9,
    ST_RDOLD,
    ST_WB,
    ST_SEED,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic               en;
    logic [POOL_AW-1:0] addr;
    logic [DATA_W-1:0]  data;
  } pool_wr_t;

endpackage

### rtl/well512_ram.sv
// ----------------------------------------------------------------------------
// well512_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module well512_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/well512_hash.sv
// ----------------------------------------------------------------------------
// well512_hash
// Wang 32-bit integer hash, pipelined through the s1 and s2 registers; emits
// one pool write request per issued index, from the s2 register.
// ----------------------------------------------------------------------------
module well512_hash (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  input  logic [well512_pkg::POOL_AW-1:0]        in_idx_i,
  input  logic [well512_pkg::DATA_W-1:0]         in_value_i,
  output well512_pkg::pool_wr_t                  wr_o,
  output logic                                   busy_o
);
  import well512_pkg::*;

  logic [DATA_W-1:0]  v1, v2, v3;
  logic               s1_valid_q, s2_valid_q;
  logic [POOL_AW-1:0] s1_idx_q, s2_idx_q;
  logic [DATA_W-1:0]  s1_val_q, s2_val_q;
  logic [DATA_W-1:0]  s2_val_d;

  always_comb begin
    v1 = (in_value_i ^ WANG_XOR) ^ (in_value_i >> 16);
    v2 = v1 + (v1 << 3);
    v3 = v2 ^ (v2 >> 4);
  end

  assign s2_val_d = s1_val_q * WANG_MUL;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= in_idx_i;
    s1_val_q <= v3;
    s2_idx_q <= s1_idx_q;
    s2_val_q <= s2_val_d;
  end

  always_comb begin
    wr_o.en   = s2_valid_q;
    wr_o.addr = s2_idx_q;
    wr_o.data = s2_val_q ^ (s2_val_q >> 15);
  end

  assign busy_o = s1_valid_q | s2_valid_q;

endmodule

### rtl/well512_generator.sv
// ----------------------------------------------------------------------------
// well512_generator
// WELL512a pseudo-random word generator with a sixteen-word pool in RAM.
// ----------------------------------------------------------------------------
// A draw request (tuser = 0) returns one 32-bit word; a reseed request
// (tuser = 1) fills the pool from the seed in tdata and returns nothing. The
// pool holds garbage until the first reseed, so send a reseed first. A draw
// steps through RD13, RD9, RDOLD and WB before another request is taken:
// the pool sits in one RAM with a single read port, and a draw needs four
// reads there; WB waits while the output register is full. A reseed issues
// sixteen pool writes one per cycle into the hash pipeline and drains it. A
// finished word waits in the output register while the next one is taken.
module well512_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [31:0]                       s_axis_tdata_i,  // [31:0] seed_value
  input  logic [0:0]                        s_axis_tuser_i,  // [0] mode
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [31:0]                       m_axis_tdata_o   // [31:0] random_value
);
  import well512_pkg::*;

  state_e             state_q, state_d;
  logic [POOL_AW-1:0] pos_q, pos_d;
  logic [POOL_AW-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0]  seed_q, seed_d;
  logic [DATA_W-1:0]  w0_q, w0_d;
  logic [DATA_W-1:0]  mix_q, mix_d;
  logic [DATA_W-1:0]  t9_q, t9_d;
  logic [DATA_W-1:0]  fresh_q, fresh_d;
  logic               out_vld_q, out_vld_d;
  logic [DATA_W-1:0]  out_data_q, out_data_d;

  logic               accept;
  logic               out_free;
  logic               out_load;
  logic [DATA_W-1:0]  rdata;
  logic [POOL_AW-1:0] raddr;
  logic [DATA_W-1:0]  twist;
  logic [DATA_W-1:0]  new_word;
  logic               hash_issue;
  logic               hash_busy;
  pool_wr_t           hash_wr;
  pool_wr_t           draw_wr;
  pool_wr_t           ram_wr;

  assign accept   = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free = ~out_vld_q | m_axis_tready_i;

  well512_ram #(
    .WIDTH (DATA_W),
    .DEPTH (POOL_DEPTH)
  ) u_pool (
    .clk_i   (clk_i),
    .we_i    (ram_wr.en),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  well512_hash u_hash (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (hash_issue),
    .in_idx_i   (cnt_q),
    .in_value_i (seed_q + DATA_W'(cnt_q)),
    .wr_o       (hash_wr),
    .busy_o     (hash_busy)
  );

  always_comb begin
    twist    = fresh_q ^ ((fresh_q << 5) & WELL_MAT_MASK);
    new_word = rdata ^ mix_q ^ twist ^ (rdata << 2) ^ (mix_q << 18) ^ (t9_q << 28);
    t9_d     = rdata ^ (rdata >> 11);
    fresh_d  = mix_q ^ t9_d;
    w0_d     = rdata;
    mix_d    = w0_q ^ rdata ^ (w0_q << 16) ^ (rdata << 15);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (s_axis_tuser_i[0] == MODE_RESEED) ? ST_SEED : ST_RD13;
        end
      end
      ST_RD13:  state_d = ST_RD9;
      ST_RD9:   state_d = ST_RDOLD;
      ST_RDOLD: state_d = ST_WB;
      ST_WB: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SEED: begin
        if (cnt_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!hash_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    s_axis_tready_o = 1'b0;
    raddr           = pos_q;
    draw_wr         = '0;
    hash_issue      = 1'b0;
    out_load        = 1'b0;
    pos_d           = pos_q;
    cnt_d           = cnt_q;
    seed_d          = seed_q;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        raddr           = pos_q;
        if (accept && s_axis_tuser_i[0] == MODE_RESEED) begin
          seed_d = s_axis_tdata_i;
          cnt_d  = '0;
          pos_d  = '0;
        end
      end
      ST_RD13: raddr = pos_q + OFS_M1;
      ST_RD9:  raddr = pos_q + OFS_M2;
      ST_RDOLD: begin
        raddr        = pos_q + OFS_BACK;
        draw_wr.en   = 1'b1;
        draw_wr.addr = pos_q;
        draw_wr.data = fresh_d;
      end
      ST_WB: begin
        raddr = pos_q + OFS_BACK;
        if (out_free) begin
          draw_wr.en   = 1'b1;
          draw_wr.addr = pos_q + OFS_BACK;
          draw_wr.data = new_word;
          out_load     = 1'b1;
          pos_d        = pos_q + OFS_BACK;
        end
      end
      ST_SEED: begin
        hash_issue = 1'b1;
        cnt_d      = cnt_q + POOL_AW'(1);
      end
      ST_DRAIN: ;
      default: ;
    endcase
  end

  assign ram_wr     = hash_wr.en ? hash_wr : draw_wr;
  assign out_vld_d  = out_load | (out_vld_q & ~m_axis_tready_i);
  assign out_data_d = out_load ? new_word : out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pos_q     <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seed_q     <= seed_d;
    out_data_q <= out_data_d;
    if (state_q == ST_RD13) begin
      w0_q <= w0_d;
    end
    if (state_q == ST_RD9) begin
      mix_q <= mix_d;
    end
    if (state_q == ST_RDOLD) begin
      t9_q    <= t9_d;
      fresh_q <= fresh_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_wr.en |-> state_q != ST_IDLE)
    else $error("pool write while idle");

  a_hash_wr_in_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_wr.en |-> (state_q == ST_SEED || state_q == ST_DRAIN))
    else $error("hash write outside reseed");

  a_rdold_to_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RDOLD |=> state_q == ST_WB)
    else $error("draw sequence broken");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> pos_q == $past(pos_q + OFS_BACK))
    else $error("position not moved back");

  a_load_only_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_vld_q ##1 out_vld_q) |-> $past(state_q) == ST_WB)
    else $error("result produced outside write-back");
`endif

endmodule

### tb/sv/well512_generator_tb.sv
// ----------------------------------------------------------------------------
// well512_generator_tb
// Self-checking bench for the WELL512a generator. Reseed and draw requests
// go in over the slave stream, with random sender gaps and receiver stalls in
// the gap test. A behavioural copy of the pool and position works out each
// expected word, and every returned word is compared in order.
// ----------------------------------------------------------------------------
module well512_generator_tb;
  import well512_pkg::*;

  localparam logic        MODE_DRAW      = 1'b0;
  localparam int unsigned RING_SIZE      = 16;
  localparam logic [31:0] TWIST_MASK     = 32'hDA44_2D24;
  localparam logic [31:0] HASH_MUL       = 32'h27D4_EB2D;
  localparam logic [31:0] HASH_XOR       = 32'd61;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i  = '0;  // [31:0] seed_value
  logic [0:0]  s_axis_tuser_i  = '0;  // [0] mode
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;       // [31:0] random_value

  logic [31:0] ring_words [RING_SIZE];
  logic [3:0]  ring_pos;
  logic [31:0] pending_words [$];
  logic [31:0] oldest_word;
  int unsigned mismatches    = 0;
  int unsigned idle_cycles   = 0;
  int unsigned stall_left    = 0;
  bit          gaps_on       = 1'b0;

  well512_generator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(10, 40);
    end
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [31:0] wang_hash(logic [31:0] v);
    v = (v ^ HASH_XOR) ^ (v >> 16);
    v = v * 32'd9;
    v = v ^ (v >> 4);
    v = v * HASH_MUL;
    v = v ^ (v >> 15);
    return v;
  endfunction

  task automatic fill_ring(input logic [31:0] seed);
    for (int i = 0; i < RING_SIZE; i++) begin
      ring_words[i] = wang_hash(seed + 32'(i));
    end
    ring_pos = '0;
  endtask

  task automatic next_word(output logic [31:0] word);
    logic [3:0]  p;
    logic [3:0]  i13;
    logic [3:0]  i9;
    logic [31:0] w0;
    logic [31:0] w13;
    logic [31:0] w9;
    logic [31:0] mix;
    logic [31:0] t9;
    logic [31:0] fresh;
    logic [31:0] twist;
    logic [31:0] old;
    p     = ring_pos;
    i13   = p + 4'd13;
    i9    = p + 4'd9;
    w0    = ring_words[p];
    w13   = ring_words[i13];
    w9    = ring_words[i9];
    mix   = w0 ^ w13 ^ (w0 << 16) ^ (w13 << 15);
    t9    = w9 ^ (w9 >> 11);
    fresh = mix ^ t9;
    twist = fresh ^ ((fresh << 5) & TWIST_MASK);
    ring_words[p] = fresh;
    p     = p - 4'd1;
    ring_pos = p;
    old   = ring_words[p];
    ring_words[p] = old ^ mix ^ twist ^ (old << 2) ^ (mix << 18) ^ (t9 << 28);
    word  = ring_words[p];
  endtask

  task automatic send_request(input logic mode, input logic [31:0] seed);
    int unsigned gap;
    logic [31:0] word;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= seed;
    s_axis_tuser_i  <= mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (mode == MODE_RESEED) begin
      fill_ring(seed);
    end else begin
      next_word(word);
      pending_words.push_back(word);
    end
  endtask

  task automatic run_mix(input int unsigned count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_request(MODE_RESEED, $urandom());
      end else begin
        send_request(MODE_DRAW, $urandom());
      end
    end
  endtask

  task automatic test_directed();
    gaps_on = 1'b0;
    send_request(MODE_RESEED, 32'h0000_0000);
    repeat (4) send_request(MODE_DRAW, 32'h0000_0000);
    send_request(MODE_DRAW, 32'hFFFF_FFFF);
    send_request(MODE_DRAW, 32'hA5A5_5A5A);
    send_request(MODE_RESEED, 32'hFFFF_FFFF);
    repeat (3) send_request(MODE_DRAW, 32'h5A5A_A5A5);
    send_request(MODE_RESEED, 32'hFFFF_FFF8);
    send_request(MODE_RESEED, 32'h8000_0000);
    repeat (2) send_request(MODE_DRAW, 32'h0000_0001);
    send_request(MODE_RESEED, 32'h7FFF_FFFF);
    repeat (6) send_request(MODE_DRAW, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_back_to_back();
    gaps_on = 1'b0;
    run_mix(100);
  endtask

  task automatic test_random_with_gaps();
    gaps_on = 1'b1;
    send_request(MODE_RESEED, $urandom());
    run_mix(300);
  endtask

  always @(posedge clk_i) begin
    if (!gaps_on) begin
      m_axis_tready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left      <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_words.size() == 0) begin
        $display("%0t: random_value unexpected: expected none, actual %h",
                 $time, m_axis_tdata_o);
        mismatches++;
      end else begin
        oldest_word = pending_words.pop_front();
        if (m_axis_tdata_o !== oldest_word) begin
          $display("%0t: random_value mismatch: expected %h, actual %h",
                   $time, oldest_word, m_axis_tdata_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_back_to_back();
    test_random_with_gaps();
    s_axis_tvalid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
